/* rtl/mp2d_pkg.sv */
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared types and constants of the streaming 2-D max pooling block.
// ----------------------------------------------------------------------------
package mp2d_pkg;

    // Field widths of the streams
    localparam int SAMPLE_W     = 16;
    localparam int OUT_ROW_W    = 8;
    localparam int OUT_COL_W    = 8;
    localparam int OUT_CH_W     = 4;
    localparam int OUT_FIELDS_W = SAMPLE_W + OUT_ROW_W + OUT_COL_W + OUT_CH_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int STRIDE_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE        = 3'd4;

    // Raw register contents, as written
    typedef struct packed {
        logic [8:0]          image_height;
        logic [8:0]          image_width;
        logic [4:0]          channel_count;
        logic [2:0]          window_size;
        logic [STRIDE_W-1:0] stride;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        image_height:  9'd256,
        image_width:   9'd256,
        channel_count: 5'd1,
        window_size:   3'd2,
        stride:        3'd2
    };

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cand;
        logic div_done;
        logic hit;
        logic rd_last;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/mp2d_div.sv */
// ----------------------------------------------------------------------------
// mp2d_div
// Iterative restoring divider by the stride, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module mp2d_div
    import mp2d_pkg::*;
#(
    parameter int DW = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DW-1:0]       i_dividend,
    input  logic [STRIDE_W-1:0] i_divisor,
    output logic                o_done,
    output logic [DW-1:0]       o_quotient,
    output logic                o_rem_zero
);

    localparam int PW   = DW + (DW % 2);
    localparam int NCYC = PW / 2;
    localparam int CNTW = $clog2(NCYC + 1);

    logic [PW-1:0]       r_quo, n_quo;
    logic [STRIDE_W-1:0] r_rem, n_rem;
    logic [STRIDE_W-1:0] r_div;
    logic [CNTW-1:0]     r_cnt;

    // Two restoring steps: shift in a dividend bit, subtract when it fits.
    always_comb begin
        logic [STRIDE_W:0] t;
        n_quo = r_quo;
        n_rem = r_rem;
        t     = '0;
        for (int k = 0; k < 2; k++) begin
            t     = {n_rem, n_quo[PW-1]};
            n_quo = {n_quo[PW-2:0], 1'b0};
            if (t >= {1'b0, r_div}) begin
                n_rem    = STRIDE_W'(t - {1'b0, r_div});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = t[STRIDE_W-1:0];
            end
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNTW'(NCYC);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Partial quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= PW'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = (r_cnt == '0);
    assign o_quotient = r_quo[DW-1:0];
    assign o_rem_zero = (r_rem == '0);

endmodule

/* rtl/mp2d_datapath.sv */
// ----------------------------------------------------------------------------
// mp2d_datapath
// Position counters, line store, window read-out, maximum and result register.
// ----------------------------------------------------------------------------
module mp2d_datapath
    import mp2d_pkg::*;
#(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_WINDOW   = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cfg                        i_cfg,
    input  t_dp_cmd                     i_cmd,
    output t_dp_status                  o_status,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [OUT_DATA_W-1:0]       o_out_data,
    output logic                        o_out_last
);

    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CLW   = $clog2(MAX_WIDTH);
    localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SLW   = $clog2(MAX_WINDOW);
    localparam int KW    = $clog2(MAX_WINDOW + 1);
    localparam int DEPTH = MAX_WINDOW * MAX_WIDTH * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_HEIGHT + MAX_WIDTH + 2 * MAX_WINDOW + 1024) + 1;

    // Register value 0 acts as 1, values above the limit act as the limit.
    function automatic logic [CW-1:0] clamp(input logic [CW-1:0] v, input logic [CW-1:0] hi);
        logic [CW-1:0] res;
        if (v == '0) begin
            res = CW'(1);
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Line store address of a row slot, column and channel.
    function automatic logic [AW-1:0] addr(input logic [SLW-1:0] slot,
                                           input logic [CLW-1:0] col,
                                           input logic [CHW-1:0] chn);
        return (AW'(slot) * AW'(MAX_WIDTH) + AW'(col)) * AW'(MAX_CHANNELS) + AW'(chn);
    endfunction

    // Position of the next sample and its slot in the line store
    logic [RW-1:0]  r_row, n_row;
    logic [CLW-1:0] r_col, n_col;
    logic [CHW-1:0] r_ch,  n_ch;
    logic [SLW-1:0] r_slot, n_slot;

    // Window under work
    logic [CLW-1:0] r_left;
    logic [CHW-1:0] r_win_ch;
    logic           r_last;
    logic [SLW-1:0] r_rd_slot;
    logic [KW-1:0]  r_i, r_j;
    logic           r_rd_vld;
    logic           r_first;
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic signed [SAMPLE_W-1:0] r_best;
    logic [SAMPLE_W-1:0]        r_mem [DEPTH];

    // Result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;

    // Effective configuration and window decode for the current position
    logic [CW-1:0]       h_eff, w_eff, nc_eff, k_eff;
    logic [STRIDE_W-1:0] s_eff;
    logic [CW-1:0]       r_x, c_x, ch_x, top_x, left_x;
    logic                cand, last;
    logic [SLW-1:0]      top_slot;
    logic [AW-1:0]       waddr, raddr;
    logic [KW-1:0]       k_m1;
    logic [RW-1:0]       quo_row;
    logic [CLW-1:0]      quo_col;
    logic                done_row, done_col, rz_row, rz_col;

    always_comb begin
        logic [CW-1:0] tmp;
        h_eff  = clamp(CW'(i_cfg.image_height),  CW'(MAX_HEIGHT));
        w_eff  = clamp(CW'(i_cfg.image_width),   CW'(MAX_WIDTH));
        nc_eff = clamp(CW'(i_cfg.channel_count), CW'(MAX_CHANNELS));
        k_eff  = clamp(CW'(i_cfg.window_size),   CW'(MAX_WINDOW));
        s_eff  = (i_cfg.stride == '0) ? STRIDE_W'(1) : i_cfg.stride;
        k_m1   = KW'(k_eff - CW'(1));
        r_x    = CW'(r_row);
        c_x    = CW'(r_col);
        ch_x   = CW'(r_ch);
        top_x  = r_x + CW'(1) - k_eff;
        left_x = c_x + CW'(1) - k_eff;
        cand   = (r_x < h_eff) && (c_x < w_eff) && (ch_x < nc_eff)
              && (r_x + CW'(1) >= k_eff) && (c_x + CW'(1) >= k_eff);
        last   = (top_x + CW'(s_eff) + k_eff > h_eff)
              && (left_x + CW'(s_eff) + k_eff > w_eff)
              && (ch_x + CW'(1) == nc_eff);
        // Slot of the window's top row, k - 1 steps back around the ring
        tmp = CW'(r_slot) + CW'(MAX_WINDOW) - (k_eff - CW'(1));
        if (tmp >= CW'(MAX_WINDOW)) begin
            tmp = tmp - CW'(MAX_WINDOW);
        end
        top_slot = SLW'(tmp);
        waddr    = addr(r_slot, r_col, r_ch);
        raddr    = addr(r_rd_slot, CLW'(CW'(r_left) + CW'(r_j)), r_win_ch);
    end

    // Raster advance: channel fastest, then column, then row
    always_comb begin
        logic [CW-1:0] ch1, c1, r1;
        ch1 = ch_x + CW'(1);
        c1  = c_x;
        r1  = r_x;
        if (ch1 >= nc_eff) begin
            ch1 = '0;
            c1  = c_x + CW'(1);
            if (c1 >= w_eff) begin
                c1 = '0;
                r1 = r_x + CW'(1);
                if (r1 >= h_eff) begin
                    r1 = '0;
                end
            end
        end
        if (c1 >= w_eff) begin
            c1 = '0;
        end
        if (r1 >= h_eff) begin
            r1 = '0;
        end
        n_row = RW'(r1);
        n_col = CLW'(c1);
        n_ch  = CHW'(ch1);
        if (r1 == '0) begin
            n_slot = '0;
        end else if (n_row != r_row) begin
            n_slot = (r_slot == SLW'(MAX_WINDOW - 1)) ? '0 : r_slot + 1'b1;
        end else begin
            n_slot = r_slot;
        end
    end

    // Position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_ch   <= '0;
            r_slot <= '0;
        end else if (i_cmd.accept) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_ch   <= n_ch;
            r_slot <= n_slot;
        end
    end

    // Line store: one write port for the incoming beat, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[waddr] <= i_sample;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    // Window origin and read-out counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_left    <= CLW'(left_x);
            r_win_ch  <= r_ch;
            r_last    <= last;
            r_rd_slot <= top_slot;
            r_i       <= '0;
            r_j       <= '0;
        end else if (i_cmd.rd_issue) begin
            if (r_j == k_m1) begin
                r_j       <= '0;
                r_i       <= r_i + 1'b1;
                r_rd_slot <= (r_rd_slot == SLW'(MAX_WINDOW - 1)) ? '0 : r_rd_slot + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    // Read data valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_issue;
        end
    end

    // Running maximum; the first value read seeds it
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_first <= 1'b1;
        end else if (r_rd_vld) begin
            r_first <= 1'b0;
            if (r_first || (r_rd_data > r_best)) begin
                r_best <= r_rd_data;
            end
        end
    end

    // Output position: window origin divided by the stride
    mp2d_div #(.DW(RW)) u_div_row (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.accept),
        .i_dividend (RW'(top_x)),
        .i_divisor  (s_eff),
        .o_done     (done_row),
        .o_quotient (quo_row),
        .o_rem_zero (rz_row)
    );

    mp2d_div #(.DW(CLW)) u_div_col (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.accept),
        .i_dividend (CLW'(left_x)),
        .i_divisor  (s_eff),
        .o_done     (done_col),
        .o_quotient (quo_col),
        .o_rem_zero (rz_col)
    );

    // Result register, freed when the downstream side takes the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= OUT_DATA_W'({OUT_CH_W'(r_win_ch), OUT_COL_W'(quo_col),
                                       OUT_ROW_W'(quo_row), r_best});
            r_out_last <= r_last;
        end
    end

    // Status to the controller
    always_comb begin
        o_status.cand     = cand;
        o_status.div_done = done_row && done_col;
        o_status.hit      = rz_row && rz_col;
        o_status.rd_last  = (r_i == k_m1) && (r_j == k_m1);
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

/* rtl/mp2d_ctrl.sv */
// ----------------------------------------------------------------------------
// mp2d_ctrl
// Sequencer: takes a beat, checks the stride grid, reads the window, emits.
// ----------------------------------------------------------------------------
module mp2d_ctrl
    import mp2d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.cand) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = i_status.hit ? ST_READ : ST_IDLE;
                end
            end
            ST_READ: begin
                if (i_status.rd_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready     = (r_state == ST_IDLE);
        o_cmd.accept   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.rd_issue = (r_state == ST_READ);
        o_cmd.out_load = (r_state == ST_EMIT) && i_status.out_free;
    end

endmodule

/* rtl/max_pool_2d_stream.sv */
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// Streaming 2-D max pooling over an interleaved multi-channel feature map.
// ----------------------------------------------------------------------------
// Flow: samples that end no window are taken back to back. At a window end the
//   input stalls while the stride dividers run; on the stride grid it also
//   stalls through the k*k line store reads, which go through its single read
//   port, and until the result register is free.
// Result path: dividers, window reads, drain state, then the result register.
// Reset: synchronous, active low; counters cleared, line store left as is.
module max_pool_2d_stream
    import mp2d_pkg::*;
#(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_WINDOW   = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input samples
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [SAMPLE_W-1:0]   i_s_axis_tdata,   // [15:0] sample
    // Pooled results
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [15:0] pooled_value, [23:16] out_row,
                                                    // [31:24] out_col, [35:32] channel
    output logic                  o_m_axis_tlast,   // frame_last
    // Configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       r_cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    // Configuration registers, always ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_HEIGHT:  r_cfg.image_height  <= i_cfg_data[8:0];
                CFG_IMAGE_WIDTH:   r_cfg.image_width   <= i_cfg_data[8:0];
                CFG_CHANNEL_COUNT: r_cfg.channel_count <= i_cfg_data[4:0];
                CFG_WINDOW_SIZE:   r_cfg.window_size   <= i_cfg_data[2:0];
                CFG_STRIDE:        r_cfg.stride        <= i_cfg_data[STRIDE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    mp2d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    mp2d_datapath #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_sample    (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule

/* rtl/mp2d_checker.sv */
// ----------------------------------------------------------------------------
// mp2d_checker
// Port-level checks of the max pooling block, bound to its top level.
// ----------------------------------------------------------------------------
module mp2d_checker
    import mp2d_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                  o_m_axis_tlast
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result beat changed while stalled");

    // A new result never follows an input beat in the very next cycle.
    a_out_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(i_s_axis_tvalid && o_s_axis_tready))
        else $error("result raised right after an input beat");

    // Padding bits of the result beat are zero.
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[OUT_DATA_W-1:OUT_FIELDS_W] == '0))
        else $error("result padding not zero");

    // Reset drops the result valid.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind max_pool_2d_stream mp2d_checker u_mp2d_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
